@@ rtl/dcss_pkg.sv @@
package dcss_pkg;

	localparam int unsigned DAY_W      = 6;
	localparam int unsigned MONTH_W    = 5;
	localparam int unsigned YEAR_W     = 8;
	localparam int unsigned TARGET_W   = 15;
	localparam int unsigned DAYNUM_W   = 17;
	localparam int unsigned LEFT_W     = 14;
	localparam int unsigned SEG_W      = 7;
	localparam int unsigned QUOT_W     = 7;

	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [LEFT_W-1:0] DAYS_SATURATE = 14'd9999;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 5'd12;
	localparam logic [MONTH_W-1:0] FEBRUARY   = 5'd2;

	// x / 100 for x < 10000 as (x * 5243) >> 19
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int unsigned RECIP_100_SH = 19;
	// x / 10 for x < 100 as (x * 205) >> 11
	localparam logic [7:0]  RECIP_10    = 8'd205;
	localparam int unsigned RECIP_10_SH  = 11;

	typedef enum logic [1:0] {
		STATUS_FUTURE = 2'd0,
		STATUS_TODAY  = 2'd1,
		STATUS_PAST   = 2'd2
	} status_t;

	// first day of each month in a common year, indexed by month - 1
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd31;
			4'd2:  r = 9'd59;
			4'd3:  r = 9'd90;
			4'd4:  r = 9'd120;
			4'd5:  r = 9'd151;
			4'd6:  r = 9'd181;
			4'd7:  r = 9'd212;
			4'd8:  r = 9'd243;
			4'd9:  r = 9'd273;
			4'd10: r = 9'd304;
			4'd11: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// segment a in bit 0
	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] r;
		case (digit)
			4'd0: r = 7'h3F;
			4'd1: r = 7'h06;
			4'd2: r = 7'h5B;
			4'd3: r = 7'h4F;
			4'd4: r = 7'h66;
			4'd5: r = 7'h6D;
			4'd6: r = 7'h7D;
			4'd7: r = 7'h07;
			4'd8: r = 7'h7F;
			4'd9: r = 7'h6F;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	// high nibble times ten plus low nibble, nibbles above nine included
	function automatic logic [7:0] bcd_value(input logic [7:0] v);
		return 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
	endfunction

endpackage

@@ rtl/dcss_day_number.sv @@
module dcss_day_number (
	input  logic [dcss_pkg::YEAR_W-1:0]          year,
	input  logic [dcss_pkg::MONTH_W-1:0]         month,
	input  logic [dcss_pkg::DAY_W-1:0]           day,
	output logic signed [dcss_pkg::DAYNUM_W-1:0] day_num
);

	logic [dcss_pkg::MONTH_W-1:0]  month_c;
	logic [8:0]                    offs;
	logic                          leap_add;
	logic [8:0]                    leap_days;
	logic [dcss_pkg::DAYNUM_W-1:0] base;

	always_comb begin
		month_c = (month > dcss_pkg::LAST_MONTH) ? dcss_pkg::LAST_MONTH : month;
		offs = 9'd0;
		leap_add = 1'b0;
		if (month_c != '0) begin
			offs = dcss_pkg::month_start(4'(month_c - 5'd1));
			leap_add = (year[1:0] == 2'b00) && (month_c > dcss_pkg::FEBRUARY);
		end
		// leap days of all earlier years
		leap_days = ({1'b0, year} + 9'd3) >> 2;
		base = 17'({9'd0, year} * {8'd0, dcss_pkg::DAYS_PER_YEAR})
			+ {8'd0, leap_days} + {8'd0, offs} + {16'd0, leap_add}
			+ {11'd0, day};
		// day zero drops to minus one
		day_num = signed'(base - 17'd1);
	end

endmodule

@@ rtl/date_countdown_seven_segment_core.sv @@
// date countdown to a target day with seven-segment digit codes
// input channel: in_valid/in_ready with day_bcd, month_bcd, year_bcd, one BCD
//   date per request, years counted from 2000
// config channel: cfg_valid/cfg_ready with cfg_data, the target day number
//   (days since 1 January 2000); cfg_ready is always high, write only when idle
// output channel: out_valid/out_ready with status_code, alarm_on, days_left and
//   four segment codes; exactly one result per request, in order
// five register stages: decode, day difference, status and saturation,
//   divide by hundred, digit split and segment lookup
// a request passes the decode, difference, status, divide and segment
//   registers in turn before out_valid rises; one request is accepted
//   every cycle while the receiver takes results
// each stage holds its own valid bit and loads when it is empty or its
//   successor moves, so a stalled receiver fills the stages behind it and
//   in_ready drops only when all five hold a request
// reset clears all valid bits and sets the target day number to zero
module date_countdown_seven_segment_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dcss_pkg::TARGET_W-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dcss_pkg::DAY_W-1:0]         day_bcd,
	input  logic [dcss_pkg::MONTH_W-1:0]       month_bcd,
	input  logic [dcss_pkg::YEAR_W-1:0]        year_bcd,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status_code,
	output logic                               alarm_on,
	output logic [dcss_pkg::LEFT_W-1:0]        days_left,
	output logic [dcss_pkg::SEG_W-1:0]         seg_thousands,
	output logic [dcss_pkg::SEG_W-1:0]         seg_hundreds,
	output logic [dcss_pkg::SEG_W-1:0]         seg_tens,
	output logic [dcss_pkg::SEG_W-1:0]         seg_units
);

	logic [dcss_pkg::TARGET_W-1:0] target_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic r_s1, r_s2, r_s3, r_s4, r_s5;

	logic [dcss_pkg::YEAR_W-1:0]  year_s1;
	logic [dcss_pkg::MONTH_W-1:0] month_s1;
	logic [dcss_pkg::DAY_W-1:0]   day_s1;

	logic signed [dcss_pkg::DAYNUM_W-1:0] day_num;
	logic signed [dcss_pkg::DAYNUM_W-1:0] diff_s2;

	dcss_pkg::status_t              status_s3, status_s4, status_s5;
	logic [dcss_pkg::LEFT_W-1:0]    left_s3, left_s4, left_s5;
	logic [dcss_pkg::QUOT_W-1:0]    quot_s4, rem_s4;

	dcss_pkg::status_t              status_d3;
	logic [dcss_pkg::LEFT_W-1:0]    left_d3;
	logic [26:0]                    prod100;
	logic [dcss_pkg::QUOT_W-1:0]    quot_d4, rem_d4;
	logic [13:0]                    rem_full;
	logic [14:0]                    prod_q, prod_r;
	logic [3:0]                     th_d, hu_d, te_d, un_d;
	logic [dcss_pkg::SEG_W-1:0]     seg3_d, seg2_d, seg1_d, seg0_d;
	logic [dcss_pkg::SEG_W-1:0]     seg3_s5, seg2_s5, seg1_s5, seg0_s5;
	logic                           fut;

	// handshake chain, a stage loads when empty or when its successor moves
	assign r_s5 = !v_s5 || out_ready;
	assign r_s4 = !v_s4 || r_s5;
	assign r_s3 = !v_s3 || r_s4;
	assign r_s2 = !v_s2 || r_s3;
	assign r_s1 = !v_s1 || r_s2;
	assign in_ready = r_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (cfg_valid)
				target_q <= cfg_data;
			if (r_s1)
				v_s1 <= in_valid;
			if (r_s2)
				v_s2 <= v_s1;
			if (r_s3)
				v_s3 <= v_s2;
			if (r_s4)
				v_s4 <= v_s3;
			if (r_s5)
				v_s5 <= v_s4;
		end
	end

	dcss_day_number u_day_number (
		.year    (year_s1),
		.month   (month_s1),
		.day     (day_s1),
		.day_num (day_num)
	);

	always_comb begin
		if (diff_s2 > 17'sd0) begin
			status_d3 = dcss_pkg::STATUS_FUTURE;
			if (diff_s2 > signed'({3'd0, dcss_pkg::DAYS_SATURATE}))
				left_d3 = dcss_pkg::DAYS_SATURATE;
			else
				left_d3 = diff_s2[dcss_pkg::LEFT_W-1:0];
		end else if (diff_s2 == 17'sd0) begin
			status_d3 = dcss_pkg::STATUS_TODAY;
			left_d3 = '0;
		end else begin
			status_d3 = dcss_pkg::STATUS_PAST;
			left_d3 = '0;
		end
	end

	always_comb begin
		prod100 = {13'd0, left_s3} * {14'd0, dcss_pkg::RECIP_100};
		quot_d4 = prod100[dcss_pkg::RECIP_100_SH +: dcss_pkg::QUOT_W];
		rem_full = left_s3 - 14'({7'd0, quot_d4} * 14'd100);
		rem_d4 = rem_full[dcss_pkg::QUOT_W-1:0];
	end

	always_comb begin
		prod_q = {8'd0, quot_s4} * {7'd0, dcss_pkg::RECIP_10};
		prod_r = {8'd0, rem_s4} * {7'd0, dcss_pkg::RECIP_10};
		th_d = prod_q[dcss_pkg::RECIP_10_SH +: 4];
		te_d = prod_r[dcss_pkg::RECIP_10_SH +: 4];
		hu_d = 4'(quot_s4 - 7'({3'd0, th_d} * 7'd10));
		un_d = 4'(rem_s4 - 7'({3'd0, te_d} * 7'd10));
		fut = (status_s4 == dcss_pkg::STATUS_FUTURE);
		// leading zeros blank
		seg3_d = (fut && left_s4 >= 14'd1000) ? dcss_pkg::seg_font(th_d) : '0;
		seg2_d = (fut && left_s4 >= 14'd100) ? dcss_pkg::seg_font(hu_d) : '0;
		seg1_d = (fut && left_s4 >= 14'd10) ? dcss_pkg::seg_font(te_d) : '0;
		seg0_d = fut ? dcss_pkg::seg_font(un_d) : '0;
	end

	always_ff @(posedge clk) begin
		if (r_s1 && in_valid) begin
			day_s1 <= dcss_pkg::DAY_W'(dcss_pkg::bcd_value({2'd0, day_bcd}));
			month_s1 <= dcss_pkg::MONTH_W'(dcss_pkg::bcd_value({3'd0, month_bcd}));
			year_s1 <= dcss_pkg::bcd_value(year_bcd);
		end
		if (r_s2 && v_s1)
			diff_s2 <= signed'({2'd0, target_q}) - day_num;
		if (r_s3 && v_s2) begin
			status_s3 <= status_d3;
			left_s3 <= left_d3;
		end
		if (r_s4 && v_s3) begin
			status_s4 <= status_s3;
			left_s4 <= left_s3;
			quot_s4 <= quot_d4;
			rem_s4 <= rem_d4;
		end
		if (r_s5 && v_s4) begin
			status_s5 <= status_s4;
			left_s5 <= left_s4;
			seg3_s5 <= seg3_d;
			seg2_s5 <= seg2_d;
			seg1_s5 <= seg1_d;
			seg0_s5 <= seg0_d;
		end
	end

	assign out_valid = v_s5;
	assign status_code = status_s5;
	assign alarm_on = (status_s5 == dcss_pkg::STATUS_TODAY);
	assign days_left = left_s5;
	assign seg_thousands = seg3_s5;
	assign seg_hundreds = seg2_s5;
	assign seg_tens = seg1_s5;
	assign seg_units = seg0_s5;

endmodule

@@ tb/date_countdown_seven_segment_core_tb.sv @@
module date_countdown_seven_segment_core_tb;

	localparam int SHOWN_MAX   = 9999;
	localparam int TARGET_MAX  = 32767;
	localparam int SETTLE      = 8;
	localparam int CALM_TAIL   = 150;
	localparam int STUCK_LIMIT = 4000;

	typedef enum logic [1:0] {
		REQ_DATE,
		REQ_TARGET,
		REQ_HOLD
	} req_kind_t;

	typedef struct packed {
		logic [dcss_pkg::DAY_W-1:0]   day;
		logic [dcss_pkg::MONTH_W-1:0] month;
		logic [dcss_pkg::YEAR_W-1:0]  year;
	} date_t;

	typedef struct {
		req_kind_t                       kind;
		date_t                           dt;
		logic [dcss_pkg::TARGET_W-1:0]   target;
	} req_t;

	typedef struct packed {
		dcss_pkg::status_t            status;
		logic                         alarm;
		logic [dcss_pkg::LEFT_W-1:0]  left;
		logic [dcss_pkg::SEG_W-1:0]   seg3;
		logic [dcss_pkg::SEG_W-1:0]   seg2;
		logic [dcss_pkg::SEG_W-1:0]   seg1;
		logic [dcss_pkg::SEG_W-1:0]   seg0;
	} countdown_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dcss_pkg::TARGET_W-1:0]   cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [dcss_pkg::DAY_W-1:0]      day_bcd = '0;
	logic [dcss_pkg::MONTH_W-1:0]    month_bcd = '0;
	logic [dcss_pkg::YEAR_W-1:0]     year_bcd = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [1:0]                      status_code;
	logic                            alarm_on;
	logic [dcss_pkg::LEFT_W-1:0]     days_left;
	logic [dcss_pkg::SEG_W-1:0]      seg_thousands;
	logic [dcss_pkg::SEG_W-1:0]      seg_hundreds;
	logic [dcss_pkg::SEG_W-1:0]      seg_tens;
	logic [dcss_pkg::SEG_W-1:0]      seg_units;

	req_t       date_requests[$];
	countdown_t countdown_due[$];
	int         dates_open = 0;
	int         mismatches = 0;
	int         target_now = 0;

	int month_base [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	logic [dcss_pkg::SEG_W-1:0] glyph [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

	date_countdown_seven_segment_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.day_bcd       (day_bcd),
		.month_bcd     (month_bcd),
		.year_bcd      (year_bcd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status_code   (status_code),
		.alarm_on      (alarm_on),
		.days_left     (days_left),
		.seg_thousands (seg_thousands),
		.seg_hundreds  (seg_hundreds),
		.seg_tens      (seg_tens),
		.seg_units     (seg_units)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// digits above nine still weigh ten per high step
	function automatic int bcd_num(input logic [7:0] v);
		return int'(v[7:4]) * 10 + int'(v[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(input int v);
		return 8'((v / 10) * 16 + v % 10);
	endfunction

	function automatic int day_index(input date_t dt);
		int yy;
		int mm;
		int t;
		yy = bcd_num(dt.year);
		mm = bcd_num({3'b0, dt.month});
		t = yy * 365 + (yy + 3) / 4;
		if (mm > 12)
			mm = 12;
		if (mm >= 1) begin
			t += month_base[mm-1];
			if (yy % 4 == 0 && mm > 2)
				t += 1;
		end
		t += bcd_num({2'b0, dt.day}) - 1;
		return t;
	endfunction

	function automatic countdown_t countdown_for(input date_t dt, input int target);
		countdown_t c;
		int diff;
		int left;
		diff = target - day_index(dt);
		c.alarm = 1'b0;
		c.left = '0;
		c.seg3 = '0;
		c.seg2 = '0;
		c.seg1 = '0;
		c.seg0 = '0;
		if (diff > 0) begin
			c.status = dcss_pkg::STATUS_FUTURE;
			left = (diff > SHOWN_MAX) ? SHOWN_MAX : diff;
			c.left = dcss_pkg::LEFT_W'(left);
			c.seg0 = glyph[left % 10];
			if (left >= 10)
				c.seg1 = glyph[(left / 10) % 10];
			if (left >= 100)
				c.seg2 = glyph[(left / 100) % 10];
			if (left >= 1000)
				c.seg3 = glyph[(left / 1000) % 10];
		end else if (diff == 0) begin
			c.status = dcss_pkg::STATUS_TODAY;
			c.alarm = 1'b1;
		end else begin
			c.status = dcss_pkg::STATUS_PAST;
		end
		return c;
	endfunction

	task automatic add_date(input logic [7:0] d, input logic [7:0] m, input logic [7:0] y);
		req_t r;
		r.kind = REQ_DATE;
		r.dt.day = dcss_pkg::DAY_W'(d);
		r.dt.month = dcss_pkg::MONTH_W'(m);
		r.dt.year = y;
		r.target = '0;
		date_requests.push_back(r);
		dates_open++;
	endtask

	task automatic add_target(input int v);
		req_t r;
		r.kind = REQ_TARGET;
		r.dt = '0;
		r.target = dcss_pkg::TARGET_W'(v);
		date_requests.push_back(r);
	endtask

	task automatic add_hold();
		req_t r;
		r.kind = REQ_HOLD;
		r.dt = '0;
		r.target = '0;
		date_requests.push_back(r);
	endtask

	// driver: dates, target writes and holds, in queue order
	int tx_gap = 0;
	int tx_quiet = 0;
	int settle = 0;

	always @(posedge clk) begin : drive_proc
		req_t head;
		date_t sent;
		logic nv_in;
		logic nv_cfg;
		if (arst_n) begin
			nv_in = in_valid;
			nv_cfg = cfg_valid;
			if (in_valid && in_ready) begin
				sent.day = day_bcd;
				sent.month = month_bcd;
				sent.year = year_bcd;
				countdown_due.push_back(countdown_for(sent, target_now));
				dates_open--;
				nv_in = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				target_now = int'(cfg_data);
				nv_cfg = 1'b0;
			end
			if (countdown_due.size() == 0 && !in_valid)
				settle++;
			else
				settle = 0;
			if (tx_quiet > 0)
				tx_quiet--;
			else if ($urandom_range(0, 149) == 0)
				tx_quiet = $urandom_range(50, 200);
			if (!nv_in && !nv_cfg && date_requests.size() > 0) begin
				head = date_requests[0];
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (dates_open >= CALM_TAIL && tx_quiet == 0 &&
						$urandom_range(0, 99) < 12) begin
					tx_gap = $urandom_range(1, 12) - 1;
				end else begin
					case (head.kind)
						REQ_DATE: begin
							nv_in = 1'b1;
							day_bcd <= head.dt.day;
							month_bcd <= head.dt.month;
							year_bcd <= head.dt.year;
							void'(date_requests.pop_front());
						end
						REQ_TARGET: begin
							// only once the pipeline has drained
							if (settle >= SETTLE) begin
								nv_cfg = 1'b1;
								cfg_data <= head.target;
								void'(date_requests.pop_front());
							end
						end
						REQ_HOLD: begin
							if (settle >= SETTLE)
								void'(date_requests.pop_front());
						end
						default: ;
					endcase
				end
			end
			in_valid <= nv_in;
			cfg_valid <= nv_cfg;
		end
	end

	// monitor: receiver stalls and result checks
	int rx_stall = 0;
	int rx_quiet = 0;

	always @(posedge clk) begin : watch_proc
		countdown_t want;
		logic nr;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (countdown_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no request pending: status %0d days %0d",
							status_code, days_left);
				end else begin
					want = countdown_due.pop_front();
					if (status_code !== want.status || alarm_on !== want.alarm ||
							days_left !== want.left || seg_thousands !== want.seg3 ||
							seg_hundreds !== want.seg2 || seg_tens !== want.seg1 ||
							seg_units !== want.seg0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("bad result: want st %0d al %0d days %0d seg %h %h %h %h,",
								want.status, want.alarm, want.left, want.seg3, want.seg2,
								want.seg1, want.seg0);
							$display(" got st %0d al %0d days %0d seg %h %h %h %h",
								status_code, alarm_on, days_left,
								seg_thousands, seg_hundreds, seg_tens, seg_units);
						end
					end
				end
			end
			if (rx_quiet > 0)
				rx_quiet--;
			else if ($urandom_range(0, 149) == 0)
				rx_quiet = $urandom_range(50, 200);
			if (rx_stall > 0) begin
				rx_stall--;
				nr = 1'b0;
			end else if (dates_open >= CALM_TAIL && rx_quiet == 0 &&
					$urandom_range(0, 99) < 10) begin
				rx_stall = $urandom_range(1, 12) - 1;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			out_ready <= nr;
		end
	end

	// watchdog on cycles with no handshake at all
	int stuck = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("date_countdown_seven_segment_core: mismatch");
			$finish;
		end
	end

	initial begin
		date_t anchor;
		int ay;
		int am;
		int ad;
		int ny;
		int tgt;
		int r;
		int dd;

		// reset value of the target is zero
		add_date(8'h01, 8'h01, 8'h00);
		add_date(8'h00, 8'h00, 8'h00);
		add_date(8'h02, 8'h01, 8'h00);

		anchor.day = 6'h22;
		anchor.month = 5'h08;
		anchor.year = 8'h24;
		add_target(day_index(anchor));
		add_date(8'h22, 8'h08, 8'h24);
		add_date(8'h21, 8'h08, 8'h24);
		add_date(8'h01, 8'h08, 8'h24);
		add_date(8'h01, 8'h01, 8'h24);
		add_date(8'h01, 8'h01, 8'h00);
		add_date(8'h00, 8'h00, 8'h00);
		add_date(8'h23, 8'h08, 8'h24);
		add_date(8'h31, 8'h12, 8'h99);
		add_date(8'h3F, 8'h1F, 8'hFF);
		add_date(8'h1A, 8'h0A, 8'h1A);
		add_date(8'h15, 8'h13, 8'h24);
		add_date(8'h15, 8'h1F, 8'h24);
		add_date(8'h15, 8'h00, 8'h24);
		add_date(8'h29, 8'h02, 8'h24);
		add_date(8'h01, 8'h03, 8'h24);
		add_date(8'h01, 8'h03, 8'h23);

		// far target saturates the display
		add_target(TARGET_MAX);
		add_date(8'h01, 8'h01, 8'h00);
		add_date(8'h3F, 8'h1F, 8'hFF);

		for (int p = 0; p < 10; p++) begin
			ay = $urandom_range(0, 99);
			am = $urandom_range(1, 12);
			ad = $urandom_range(4, 28);
			anchor.day = dcss_pkg::DAY_W'(to_bcd(ad));
			anchor.month = dcss_pkg::MONTH_W'(to_bcd(am));
			anchor.year = to_bcd(ay);
			case (p % 5)
				0: tgt = 0;
				1: tgt = TARGET_MAX;
				default: begin
					tgt = day_index(anchor);
					if (tgt > TARGET_MAX)
						tgt = TARGET_MAX;
				end
			endcase
			add_target(tgt);
			for (int i = 0; i < 125; i++) begin
				if ((p == 3 || p == 7) && i == 60)
					add_hold();
				r = $urandom_range(0, 99);
				ny = ay + int'($urandom_range(0, 2)) - 1;
				if (ny < 0)
					ny = 0;
				if (ny > 99)
					ny = 99;
				if (r < 15) begin
					add_date(8'($urandom), 8'($urandom), 8'($urandom));
				end else if (r < 40) begin
					// days around the anchor date, the target in passes that take it
					dd = ad + int'($urandom_range(0, 6)) - 3;
					add_date(to_bcd(dd), to_bcd(am), to_bcd(ay));
				end else if (r < 75) begin
					add_date(to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(1, 12)),
						to_bcd(ny));
				end else begin
					add_date(to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(1, 12)),
						to_bcd($urandom_range(0, 99)));
				end
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (dates_open != 0 || countdown_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("date_countdown_seven_segment_core: match");
		else
			$display("date_countdown_seven_segment_core: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dcss_pkg.sv
rtl/dcss_day_number.sv
rtl/date_countdown_seven_segment_core.sv
tb/date_countdown_seven_segment_core_tb.sv
